>>> hdl/ratio_scale_note_frequency_macros.svh
// Assertion macros used by the checker file.
// Clock and reset are taken from the enclosing scope (clk_i, rst_ni).
`ifndef RATIO_SCALE_NOTE_FREQUENCY_MACROS_SVH
`define RATIO_SCALE_NOTE_FREQUENCY_MACROS_SVH

// Same-cycle implication
`define RSNF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RSNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rsnf_pkg.sv
package rsnf_pkg;

  // Field and storage widths
  localparam int FREQ_W     = 32;
  localparam int NOTE_W     = 8;
  localparam int RATIO_W    = 16;
  localparam int SIZE_W     = 3;
  localparam int RATIO_N    = 8;
  localparam int WORD_W     = 64;
  localparam int INTV_W     = NOTE_W + 1;
  localparam int PROD_W     = FREQ_W + RATIO_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = WORD_W;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 40;
  localparam int DIV_STEPS  = FREQ_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_FREQ  = 3'd0,
    REG_ROOT_NOTE  = 3'd1,
    REG_SCALE_SIZE = 3'd2,
    REG_RATIO_LOW  = 3'd3,
    REG_RATIO_HIGH = 3'd4
  } rsnf_reg_e;

  // Reset values of the registers
  localparam logic [FREQ_W-1:0] BASE_FREQ_RST  = 32'h0100_0000;
  localparam logic [NOTE_W-1:0] ROOT_NOTE_RST  = 8'd60;
  localparam logic [SIZE_W-1:0] SCALE_SIZE_RST = 3'd5;
  localparam logic [WORD_W-1:0] RATIO_WORD_RST = '0;

  typedef struct packed {
    logic [FREQ_W-1:0]                base_freq;
    logic [NOTE_W-1:0]                root_note;
    logic [SIZE_W-1:0]                scale_size;
    logic [RATIO_N-1:0][RATIO_W-1:0]  ratios;
  } rsnf_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul_start;
    logic sel_step;
    logic mul_wb;
    logic step_up;
    logic div_start;
    logic div_step;
    logic out_load;
  } rsnf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic up_pending;
    logic down_pending;
    logic sat;
    logic div_last;
  } rsnf_status_t;

endpackage

>>> hdl/rsnf_cfg.sv
module rsnf_cfg
  import rsnf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output rsnf_cfg_t             cfg_o
);

  logic [FREQ_W-1:0] base_q;
  logic [NOTE_W-1:0] root_q;
  logic [SIZE_W-1:0] size_q;
  logic [WORD_W-1:0] lo_q;
  logic [WORD_W-1:0] hi_q;

  // Register file, writes to unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_FREQ_RST;
      root_q <= ROOT_NOTE_RST;
      size_q <= SCALE_SIZE_RST;
      lo_q   <= RATIO_WORD_RST;
      hi_q   <= RATIO_WORD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BASE_FREQ:  base_q <= cfg_data_i[FREQ_W-1:0];
        REG_ROOT_NOTE:  root_q <= cfg_data_i[NOTE_W-1:0];
        REG_SCALE_SIZE: size_q <= cfg_data_i[SIZE_W-1:0];
        REG_RATIO_LOW:  lo_q   <= cfg_data_i[WORD_W-1:0];
        REG_RATIO_HIGH: hi_q   <= cfg_data_i[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry 0 sits in the low bits of the low word
  assign cfg_o.base_freq  = base_q;
  assign cfg_o.root_note  = root_q;
  assign cfg_o.scale_size = size_q;
  assign cfg_o.ratios     = {hi_q, lo_q};

endmodule

>>> hdl/rsnf_dp.sv
module rsnf_dp
  import rsnf_pkg::*;
#(
  parameter int RATIO_FRAC_BITS = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsnf_cfg_t         cfg_i,
  input  logic [NOTE_W-1:0] note_i,
  input  rsnf_cmd_t         cmd_i,
  output rsnf_status_t      status_o,
  output logic [FREQ_W-1:0] out_freq_o,
  output logic              out_ovf_o
);

  logic [FREQ_W-1:0]         f_q;
  logic signed [INTV_W-1:0]  intv_q;
  logic                      sat_q;
  logic [PROD_W-1:0]         prod_q;
  logic [RATIO_W:0]          rem_q;
  logic [FREQ_W-1:0]         dlo_q;
  logic [DIV_CNT_W-1:0]      cnt_q;
  logic [FREQ_W-1:0]         out_freq_q;
  logic                      out_ovf_q;

  logic [SIZE_W-1:0]         size_eff;
  logic signed [INTV_W-1:0]  size_ext;
  logic [RATIO_W-1:0]        period;
  logic [RATIO_W-1:0]        step_ratio;
  logic [RATIO_W-1:0]        mul_op;
  logic [PROD_W-1:0]         prod_shift;
  logic                      mul_ovf;
  logic [2*FREQ_W-1:0]       dividend;
  logic [RATIO_W-1:0]        div_hi;
  logic                      div_ovf;
  logic [RATIO_W:0]          trial;
  logic                      qbit;
  logic [RATIO_W:0]          rem_next;
  logic                      div_last;

  // Scale size zero behaves as one step per period
  assign size_eff   = (cfg_i.scale_size == '0) ? SIZE_W'(1) : cfg_i.scale_size;
  assign size_ext   = $signed({{(INTV_W-SIZE_W){1'b0}}, size_eff});
  assign period     = cfg_i.ratios[size_eff];
  assign step_ratio = cfg_i.ratios[intv_q[SIZE_W-1:0]];
  assign mul_op     = cmd_i.sel_step ? step_ratio : period;

  // Multiply write-back: drop fraction bits, saturate above 32 bits
  assign prod_shift = prod_q >> RATIO_FRAC_BITS;
  assign mul_ovf    = |prod_shift[PROD_W-1:FREQ_W];

  // Divide set-up: quotient fits 32 bits only if the high part is below the ratio
  assign dividend = {{FREQ_W{1'b0}}, f_q} << RATIO_FRAC_BITS;
  assign div_hi   = dividend[FREQ_W +: RATIO_W];
  assign div_ovf  = (div_hi >= period);

  // One restoring division step
  assign trial    = {rem_q[RATIO_W-1:0], dlo_q[FREQ_W-1]};
  assign qbit     = (trial >= {1'b0, period});
  assign rem_next = qbit ? (trial - {1'b0, period}) : trial;
  assign div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  assign status_o.up_pending   = (intv_q >= size_ext);
  assign status_o.down_pending = intv_q[INTV_W-1];
  assign status_o.sat          = sat_q;
  assign status_o.div_last     = div_last;

  // Saturation flag is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (cmd_i.load) begin
      sat_q <= 1'b0;
    end else if ((cmd_i.mul_wb && mul_ovf) || (cmd_i.div_start && div_ovf)) begin
      sat_q <= 1'b1;
    end
  end

  // Running frequency, interval and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      f_q    <= cfg_i.base_freq;
      intv_q <= $signed({1'b0, note_i}) - $signed({1'b0, cfg_i.root_note});
    end
    if (cmd_i.mul_start) begin
      prod_q <= PROD_W'(f_q) * PROD_W'(mul_op);
    end
    if (cmd_i.mul_wb) begin
      f_q <= mul_ovf ? FREQ_MAX : prod_shift[FREQ_W-1:0];
      if (cmd_i.step_up) begin
        intv_q <= intv_q - size_ext;
      end
    end
    if (cmd_i.div_start) begin
      if (div_ovf) begin
        f_q <= FREQ_MAX;
      end
      rem_q <= {1'b0, div_hi};
      dlo_q <= dividend[FREQ_W-1:0];
      cnt_q <= '0;
    end
    // Quotient bits shift in behind the dividend bits
    if (cmd_i.div_step) begin
      rem_q <= rem_next;
      dlo_q <= {dlo_q[FREQ_W-2:0], qbit};
      cnt_q <= cnt_q + DIV_CNT_W'(1);
      if (div_last) begin
        f_q    <= {dlo_q[FREQ_W-2:0], qbit};
        intv_q <= intv_q + size_ext;
      end
    end
    if (cmd_i.out_load) begin
      out_freq_q <= f_q;
      out_ovf_q  <= sat_q;
    end
  end

  assign out_freq_o = out_freq_q;
  assign out_ovf_o  = out_ovf_q;

endmodule

>>> hdl/rsnf_ctrl.sv
module rsnf_ctrl
  import rsnf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  rsnf_status_t status_i,
  output rsnf_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL_P,
    ST_WB_P,
    ST_MUL_S,
    ST_WB_S,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_FINISH
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;

  // Command decode and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.sat) begin
          state_d = ST_FINISH;
        end else if (status_i.up_pending) begin
          state_d = ST_MUL_P;
        end else if (status_i.down_pending) begin
          state_d = ST_DIV_START;
        end else begin
          state_d = ST_MUL_S;
        end
      end
      ST_MUL_P: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_WB_P;
      end
      ST_WB_P: begin
        cmd_o.mul_wb  = 1'b1;
        cmd_o.step_up = 1'b1;
        state_d       = ST_DECIDE;
      end
      ST_MUL_S: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.sel_step  = 1'b1;
        state_d         = ST_WB_S;
      end
      ST_WB_S: begin
        cmd_o.mul_wb = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (status_i.sat) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.div_step = 1'b1;
          if (status_i.div_last) begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_FINISH: begin
        // Wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/ratio_scale_note_frequency.sv
// Note number to frequency on a repeating ratio scale.
// Input stream: one note number per item (s_axis_tdata[7:0]).
// Output stream: one result per note, frequency in Q16.16 and a saturation flag.
// Registers must be written through cfg_we_i/cfg_index_i/cfg_data_i only while
// idle; the block itself does not enforce this. They hold the base frequency,
// root note, scale size and eight Q2.14 ratio entries. Each period above the
// root costs one pass through the 32x16 multiplier and its write-back; each
// period below costs a 32-step restoring divider, one quotient bit per cycle.
// One note is worked on at a time; the next note is taken once the result has
// moved into the output register. Saturation stops the loop early.
// A finished result waits in the output register while the sink stalls; the
// input side may already accept the next note, which then waits for the
// register to free before it is written.
// Reset returns the registers to their defaults and empties the output.
module ratio_scale_note_frequency
  import rsnf_pkg::*;
#(
  parameter int RATIO_FRAC_BITS = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // note in [7:0]
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // frequency in [31:0], overflow in [32], zeros above
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  rsnf_cfg_t         cfg;
  rsnf_cmd_t         cmd;
  rsnf_status_t      status;
  logic [FREQ_W-1:0] out_freq;
  logic              out_ovf;

  rsnf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rsnf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rsnf_dp #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .note_i     (s_axis_tdata[NOTE_W-1:0]),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_freq_o (out_freq),
    .out_ovf_o  (out_ovf)
  );

  assign m_axis_tdata = {{(M_TDATA_W-FREQ_W-1){1'b0}}, out_ovf, out_freq};

endmodule

>>> hdl/rsnf_checker.sv
`include "ratio_scale_note_frequency_macros.svh"

module rsnf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A stalled result holds
  `RSNF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Overflow always comes with a saturated frequency
  `RSNF_ASSERT_IMPL(a_ovf_sat, m_axis_tvalid && m_axis_tdata[32],
    m_axis_tdata[31:0] == 32'hFFFF_FFFF, "overflow without saturation")

  // Padding bits stay clear
  `RSNF_ASSERT_IMPL(a_pad_zero, m_axis_tvalid,
    m_axis_tdata[39:33] == 7'd0, "padding bits set")

  // One note at a time: busy right after an accept
  `RSNF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
    !s_axis_tready, "note accepted while busy")

endmodule

bind ratio_scale_note_frequency rsnf_checker u_rsnf_checker (.*);
